// ===== sv/awmd_pkg.sv =====
// Package for the alpha-weighted 2x2 mip downsampler.
// Holds widths, constants, the work-queue entry type and the engine state type.
package awmd_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned PIX_W = 32;
    localparam int unsigned CFG_W = 11;
    localparam int unsigned COL_OUT_W = 9;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_BOT
    } t_state;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        odd_row;
        logic [12:0] slot;
    } t_job;

endpackage

// ===== sv/awmd_front.sv =====
// Front end: accepts pixels, tracks column and row parity, forms pair jobs.
// Depends on awmd_pkg.
module awmd_front
    import awmd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int unsigned CW = $clog2(MAX_WIDTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [CFG_W-1:0] i_width,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pixel,
    input  logic        i_frame_start,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    logic [CW-1:0] r_col, col, n_col;
    logic          r_odd, odd;
    logic [31:0]   r_left;
    logic [CW:0]   w_eff;

    always_comb begin
        if ({{(CW+1){1'b0}}, i_width} < {{(CW+1){1'b0}}, 11'd2}
            && CFG_W <= CW + 1)
            w_eff = (CW+1)'(2);
        else if (32'(i_width) > 32'(MAX_WIDTH))
            w_eff = (CW+1)'(MAX_WIDTH);
        else if (32'(i_width) < 32'd2)
            w_eff = (CW+1)'(2);
        else
            w_eff = (CW+1)'(i_width);
        col = i_frame_start ? '0 : r_col;
        odd = i_frame_start ? 1'b0 : r_odd;
        n_col = col + 1'b1;
    end

    assign o_job_valid = i_valid && col[0];
    assign o_ready = !col[0] || i_job_ready;
    assign o_job.left = r_left;
    assign o_job.right = i_pixel;
    assign o_job.odd_row = odd;
    assign o_job.slot = 13'(col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_odd <= 1'b0;
        end else if (i_valid && o_ready) begin
            if ({1'b0, n_col} >= w_eff) begin
                r_col <= '0;
                r_odd <= !odd;
            end else begin
                r_col <= n_col;
                r_odd <= odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && !col[0])
            r_left <= i_pixel;
    end
endmodule

// ===== sv/awmd_queue.sv =====
// Two-entry job queue between the front end and the blend engine.
// Depends on awmd_pkg.
module awmd_queue
    import awmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_valid && o_ready) r_wp <= !r_wp;
            if (o_valid && i_ready) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_mem[r_wp] <= i_job;
    end
endmodule

// ===== sv/awmd_blend.sv =====
// Blend engine: pair blend by restoring division, row store, output register.
// Depends on awmd_pkg.
module awmd_blend
    import awmd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int unsigned SW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel,
    output logic [8:0]  o_column
);
    localparam int unsigned DEPTH = MAX_WIDTH / 2;

    logic [31:0] r_store [DEPTH];
    t_state      r_state, n_state;
    logic [31:0] r_res, r_rd;
    logic [8:0]  r_sum;
    logic [7:0]  r_num [3];
    logic [16:0] r_rem [3];
    logic [7:0]  r_quo [3];
    logic [3:0]  r_step;
    logic        r_odd, r_second, r_alpha, r_ov;
    logic [SW-1:0] r_slot;
    logic [31:0] r_opix;
    logic [8:0]  r_ocol;
    logic        start, done;
    logic [31:0] blended;

    assign o_ready = r_state == ST_IDLE;
    assign start = i_valid && o_ready;
    assign done = r_step == 4'd8;
    assign blended = {r_alpha ? CHAN_MAX : 8'h00, r_quo[2], r_quo[1], r_quo[0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_TOP;
            ST_TOP:  if (done && !(r_odd && !r_second) ) n_state = ST_BOT;
            ST_BOT:  if (!r_ov || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_BOT && r_odd && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (o_valid && i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_pixel = r_opix;
    assign o_column = r_ocol;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BOT && r_odd && (!r_ov || i_ready)) begin
            r_opix <= r_res;
            r_ocol <= 9'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_rd <= r_store[SW'(i_job.slot)];
        if (r_state == ST_TOP && done && !r_odd) r_store[r_slot] <= blended;
    end

    // Load a pair, run eight restoring steps per channel in parallel.
    always_ff @(posedge i_clk) begin
        logic [7:0] wp, wq;
        logic [17:0] trial;
        logic [16:0] num;
        if (start) begin
            r_odd <= i_job.odd_row;
            r_slot <= SW'(i_job.slot);
            r_second <= 1'b0;
            wp = i_job.left[31:24];
            wq = i_job.right[31:24];
            r_alpha <= (wp | wq) != 8'd0;
            if ((wp | wq) == 8'd0) begin
                wp = 8'd1;
                wq = 8'd1;
            end
            r_sum <= 9'(wp) + 9'(wq);
            for (int c = 0; c < 3; c++) begin
                num = 17'(i_job.left[8*c +: 8]) * 17'(wp)
                    + 17'(i_job.right[8*c +: 8]) * 17'(wq);
                r_num[c] <= num[7:0];
                r_rem[c] <= 17'(num[16:8]);
            end
            r_step <= '0;
        end else if (r_state == ST_TOP && !done) begin
            for (int c = 0; c < 3; c++) begin
                trial = {r_rem[c], r_num[c][7]} - {9'd0, r_sum};
                if (!trial[17]) begin
                    r_rem[c] <= trial[16:0];
                    r_quo[c] <= {r_quo[c][6:0], 1'b1};
                end else begin
                    r_rem[c] <= {r_rem[c][15:0], r_num[c][7]};
                    r_quo[c] <= {r_quo[c][6:0], 1'b0};
                end
                r_num[c] <= {r_num[c][6:0], 1'b0};
            end
            r_step <= r_step + 4'd1;
        end else if (r_state == ST_TOP && done && r_odd && !r_second) begin
            r_second <= 1'b1;
            wp = r_rd[31:24];
            wq = r_alpha ? CHAN_MAX : 8'h00;
            r_alpha <= (wp | wq) != 8'd0;
            if ((wp | wq) == 8'd0) begin
                wp = 8'd1;
                wq = 8'd1;
            end
            r_sum <= 9'(wp) + 9'(wq);
            for (int c = 0; c < 3; c++) begin
                num = 17'(r_rd[8*c +: 8]) * 17'(wp) + 17'(r_quo[c]) * 17'(wq);
                r_num[c] <= num[7:0];
                r_rem[c] <= 17'(num[16:8]);
            end
            r_step <= '0;
        end else if (r_state == ST_TOP && done) begin
            r_res <= blended;
        end
    end
endmodule

// ===== sv/alpha_weighted_mip_downsampler.sv =====
// Top level of the alpha-weighted 2x2 mip downsampler.
// Depends on awmd_pkg, awmd_front, awmd_queue, awmd_blend.
//
// Input stream: s_axis_tdata = pixel_in (alpha in [31:24]), s_axis_tuser =
// frame_start. Output stream: m_axis_tdata = {mip_column, mip_pixel}.
// i_cfg_we / i_cfg_wdata set image_width; write only while idle.
// Even-column pixels are taken every cycle; each odd-column pixel forms a
// pair job that goes through a two-entry queue to the blend engine.
// The engine runs eight divider steps per pair blend; a bottom-row
// pair also blends with the stored top pair and emits one item. With
// the engine free, the pixel that completes a block goes as a job
// through the queue, both blend passes and the output register.
// Sustained rate is one pair per engine pass, set by the shared divider.
// Reset (synchronous, active low) clears counters, row parity, queue and
// output; the row store needs no clearing. A stalled receiver holds the
// output register; the engine then waits and the queue fills, after which
// s_axis_tready drops on odd columns.
module alpha_weighted_mip_downsampler
    import awmd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_in
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // mip_pixel, mip_column, zero fill
);
    logic [CFG_W-1:0] r_width;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    t_job fq_job, qb_job;
    logic [31:0] pix;
    logic [8:0]  col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width <= CFG_W'(16);
        else if (i_cfg_we) r_width <= i_cfg_wdata;
    end

    awmd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_width(r_width),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_pixel(s_axis_tdata), .i_frame_start(s_axis_tuser),
        .o_job_valid(fq_valid), .i_job_ready(fq_ready), .o_job(fq_job)
    );

    awmd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(fq_valid), .o_ready(fq_ready), .i_job(fq_job),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_job(qb_job)
    );

    awmd_blend #(.MAX_WIDTH(MAX_WIDTH)) u_blend (
        .i_clk, .i_rst_n,
        .i_valid(qb_valid), .o_ready(qb_ready), .i_job(qb_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_pixel(pix), .o_column(col)
    );

    assign m_axis_tdata = {7'd0, col, pix};
endmodule

// ===== tb/sv/tb_alpha_weighted_mip_downsampler.sv =====
// Testbench for alpha_weighted_mip_downsampler: random and directed pixel streams
// are checked against a scoreboard with its own 2x2 alpha-weighted blend predictor.
// Depends on awmd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_alpha_weighted_mip_downsampler;
    import awmd_pkg::*;

    localparam int unsigned STORE_SLOTS = MAX_WIDTH_DEF / 2;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 64;

    typedef struct {
        logic [31:0]          pixel;
        logic [COL_OUT_W-1:0] column;
    } t_mip;

    class mip_scoreboard;
        logic [CFG_W-1:0]     row_width;
        logic [31:0]          left_pixel;
        logic [31:0]          top_pairs [STORE_SLOTS];
        logic [9:0]           col_cnt;
        logic                 odd_row;
        t_mip                 expected_mips [$];
        int unsigned          mismatches;
        int unsigned          mips_seen;

        function new();
            row_width = 11'd16;
            left_pixel = '0;
            col_cnt = '0;
            odd_row = 1'b0;
            mismatches = 0;
            mips_seen = 0;
            foreach (top_pairs[i]) top_pairs[i] = '0;
        endfunction

        function logic [31:0] blend_pair(logic [31:0] p, logic [31:0] q);
            int unsigned wp, wq, acc;
            logic [31:0] res;
            wp = p[31:24];
            wq = q[31:24];
            res = ALPHA_OPAQUE;
            if (wp + wq == 0) begin
                wp = 1;
                wq = 1;
                res = '0;
            end
            for (int k = 0; k < 3; k++) begin
                acc = (p[8*k +: 8] * wp + q[8*k +: 8] * wq) / (wp + wq);
                res[8*k +: 8] = acc[7:0];
            end
            return res;
        endfunction

        function void note_pixel(logic [31:0] pix, logic frame_start);
            int unsigned eff_width, slot;
            logic [31:0] pair;
            t_mip mip;
            eff_width = row_width;
            if (eff_width < 2) eff_width = 2;
            if (eff_width > MAX_WIDTH_DEF) eff_width = MAX_WIDTH_DEF;
            if (frame_start) begin
                col_cnt = '0;
                odd_row = 1'b0;
            end
            if (!col_cnt[0]) begin
                left_pixel = pix;
            end else begin
                slot = (col_cnt >> 1) % STORE_SLOTS;
                pair = blend_pair(left_pixel, pix);
                if (!odd_row) begin
                    top_pairs[slot] = pair;
                end else begin
                    mip.pixel = blend_pair(top_pairs[slot], pair);
                    mip.column = slot[COL_OUT_W-1:0];
                    expected_mips.insert(expected_mips.size(), mip);
                end
            end
            if (col_cnt + 1 >= eff_width) begin
                col_cnt = '0;
                odd_row = ~odd_row;
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        function void check_mip(logic [47:0] data);
            t_mip mip;
            mips_seen++;
            if (expected_mips.size() == 0) begin
                $display("%0t: unexpected mip item, actual pixel %h column %0d",
                         $time, data[31:0], data[40:32]);
                mismatches++;
                return;
            end
            mip = expected_mips[0];
            expected_mips.delete(0);
            if (data[31:0] !== mip.pixel) begin
                $display("%0t: mip_pixel expected %h actual %h", $time, mip.pixel, data[31:0]);
                mismatches++;
            end
            if (data[40:32] !== mip.column) begin
                $display("%0t: mip_column expected %0d actual %0d",
                         $time, mip.column, data[40:32]);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // pixel_in
    logic        s_axis_tuser;   // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // mip_pixel, mip_column, zero fill

    mip_scoreboard sb;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    int unsigned   cycle_cnt;
    int unsigned   pixels_sent;

    alpha_weighted_mip_downsampler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("tb_alpha_weighted_mip_downsampler: FAIL");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mip(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(int unsigned phase);
        case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 50; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 50; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    task automatic send_pixel(logic [31:0] pix, logic frame_start);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(pix, frame_start);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_mips.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(logic [10:0] w);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.row_width = w;
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] pix;
        pix = $urandom;
        case ($urandom_range(3))
            0: pix[31:24] = 8'h00;
            1: pix[31:24] = CHAN_MAX;
            default: ;
        endcase
        return pix;
    endfunction

    task automatic run_phase(logic [10:0] w, int unsigned n, bit restart, int unsigned phase);
        write_width(w);
        set_idling(phase);
        for (int unsigned i = 0; i < n; i++)
            send_pixel(rand_pixel(), (restart && i == 0) || $urandom_range(47) == 0);
    endtask

    initial begin
        logic [31:0] corner_px [24];
        sb = new();
        cycle_cnt = 0;
        pixels_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        set_idling(0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 blocks: zero alphas, one-sided alphas, saturated and empty colors
        corner_px = '{32'h00FF_FFFF, 32'h0000_0000, 32'h0012_3456, 32'h00FF_00FF,
                      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFF12_3456,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFF00_0000, 32'hFF00_0000, 32'h0000_0000, 32'h00FF_FFFF,
                      32'h01FF_FFFF, 32'hFE00_0000, 32'h8080_8080, 32'h7F7F_7F7F,
                      32'h0100_0000, 32'h0000_00FF, 32'h00FF_0000, 32'h02FF_FFFF};
        write_width(11'd2);
        foreach (corner_px[i]) send_pixel(corner_px[i], i == 0);

        run_phase(11'd0, 100, 1, 1);
        run_phase(11'd1, 100, 1, 2);
        run_phase(11'd3, 150, 1, 3);
        run_phase(11'd16, 200, 1, 0);
        run_phase(11'd10, 150, 0, 1);   // shrink mid-row, no restart
        run_phase(11'd5, 150, 1, 2);
        run_phase(11'd2047, 120, 1, 3);
        run_phase(11'd1024, 60, 1, 0);
        run_phase(11'd64, 300, 1, 1);
        run_phase(11'd7, 250, 1, 2);
        wait_idle();

        $display("Sent %0d pixels over widths 0 to 2047 with sender and receiver idling;",
                 pixels_sent);
        $display("checked %0d mip items, %0d mismatches.", sb.mips_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_mips.size() == 0)
            $display("tb_alpha_weighted_mip_downsampler: PASS");
        else
            $display("tb_alpha_weighted_mip_downsampler: FAIL");
        $finish;
    end
endmodule
